### hw/rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Shared request, result and controller-to-datapath command types.
// ----------------------------------------------------------------------------
package bpa_pkg;

  typedef enum logic [1:0] {
    REQ_INIT,
    REQ_ALLOC,
    REQ_FREE,
    REQ_RESERVE
  } req_t;

  typedef enum logic [1:0] {
    RES_OK,
    RES_NOFREE,
    RES_BAD
  } res_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_CLR,
    OP_LAY,
    OP_ARD,
    OP_ANEXT,
    OP_ATAKE,
    OP_ASPLIT,
    OP_MRD,
    OP_MUP,
    OP_MSET,
    OP_RRD,
    OP_RNEXT,
    OP_RTAKE,
    OP_RSPLIT,
    OP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    res_t   code;
  } dp_cmd_t;

  typedef struct packed {
    req_t req_in;
    logic in_bad;
    req_t req_cur;
    logic clr_last;
    logic lay_done;
    logic rd_bit;
    logic a_last;
    logic a_split_done;
    logic m_stop;
    logic r_last;
    logic r_zero;
    logic out_free;
  } dp_stat_t;

endpackage

### hw/rtl/bpa_datapath.sv
// ----------------------------------------------------------------------------
// Buddy allocator datapath
// Free-mark memory, walk registers and the result register.
// ----------------------------------------------------------------------------
module bpa_datapath #(
  parameter int PAGE_COUNT  = 256,
  parameter int ORDER_COUNT = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  bpa_pkg::req_t     in_req,
  input  logic [7:0]        in_page,
  input  logic [8:0]        in_count,
  input  logic              cfg_valid,
  input  logic [8:0]        cfg_data,
  input  bpa_pkg::dp_cmd_t  cmd,
  output bpa_pkg::dp_stat_t stat,
  output logic              out_valid,
  input  logic              out_ready,
  output bpa_pkg::res_t     out_status,
  output logic [7:0]        out_start
);

  localparam int PW    = $clog2(PAGE_COUNT);
  localparam int AW    = PW + 1;
  localparam int OW    = $clog2(ORDER_COUNT);
  localparam int OV    = $clog2(ORDER_COUNT + 1);
  localparam int IW    = OW + PW;
  localparam int DEPTH = ORDER_COUNT * (2 ** PW);
  localparam int SW0   = (AW > ORDER_COUNT) ? AW : ORDER_COUNT;
  localparam int SW    = ((SW0 > 10) ? SW0 : 10) + 1;
  localparam logic [SW-1:0] PAGES = SW'(PAGE_COUNT);

  function automatic logic [SW-1:0] pw(input logic [OV-1:0] o);
    return SW'(1) << o;
  endfunction

  function automatic logic [IW-1:0] idx(input logic [OV-1:0] o, input logic [SW-1:0] p);
    return {o[OW-1:0], p[PW-1:0]};
  endfunction

  logic           mem [DEPTH];
  logic           rdata;
  logic [8:0]     pool;
  bpa_pkg::req_t  op_q;
  logic [SW-1:0]  page_q;
  logic [OV-1:0]  k_q;
  logic [IW-1:0]  clr_addr;
  logic [SW-1:0]  lay_i;
  logic [SW-1:0]  lay_n;
  logic [OV-1:0]  j;
  logic [SW-1:0]  b;
  logic [SW-1:0]  s;
  logic [OV-1:0]  mo;
  logic [OV-1:0]  ro;

  logic [3:0]     kk;
  logic [SW-1:0]  kk_pw;
  logic           cnt_bad;
  logic [SW-1:0]  in_page_w;
  logic [SW-1:0]  rest;
  logic [OV-1:0]  lk;
  logic [OV-1:0]  jm;
  logic [SW-1:0]  tgt;
  logic [SW-1:0]  bud;
  logic [SW-1:0]  rbase;
  logic [OV-1:0]  ro1;
  logic [SW-1:0]  half;
  logic [SW-1:0]  other;
  logic           we;
  logic           wbit;
  logic [IW-1:0]  waddr;
  logic [IW-1:0]  raddr;

  // Input checks: order of the request count and the per-type validity.
  always_comb begin
    kk = 4'd10;
    for (int c = 9; c >= 0; c--) begin
      if ((SW'(1) << c) >= SW'(in_count)) kk = 4'(c);
    end
    kk_pw     = SW'(1) << kk;
    cnt_bad   = (in_count == 9'd0) || (32'(kk) >= ORDER_COUNT) || (kk_pw > PAGES);
    in_page_w = SW'(in_page);
  end

  always_comb begin
    rest = lay_n - lay_i;
    lk   = '0;
    for (int o = 0; o < ORDER_COUNT; o++) begin
      if (pw(OV'(o)) <= rest) lk = OV'(o);
    end
    jm    = j - OV'(1);
    tgt   = b + pw(jm);
    bud   = s ^ pw(mo);
    rbase = page_q & ~(pw(ro) - SW'(1));
    ro1   = ro - OV'(1);
    half  = pw(ro1);
    other = ((page_q & half) != '0) ? rbase : rbase + half;
  end

  always_comb begin
    stat.req_in = in_req;
    unique case (in_req)
      bpa_pkg::REQ_INIT:  stat.in_bad = 1'b0;
      bpa_pkg::REQ_ALLOC: stat.in_bad = cnt_bad;
      bpa_pkg::REQ_FREE:  stat.in_bad = cnt_bad || ((in_page_w & (kk_pw - SW'(1))) != '0) ||
                                        (in_page_w + kk_pw > PAGES);
      default:            stat.in_bad = (in_page_w >= PAGES);
    endcase
    stat.req_cur      = op_q;
    stat.clr_last     = (32'(clr_addr) == DEPTH - 1);
    stat.lay_done     = (lay_i >= lay_n);
    stat.rd_bit       = rdata;
    stat.a_last       = (b + pw(j) >= PAGES) && (32'(j) == ORDER_COUNT - 1);
    stat.a_split_done = (j == k_q);
    stat.m_stop       = (32'(mo) + 1 >= ORDER_COUNT) || (bud >= PAGES);
    stat.r_last       = (32'(ro) == ORDER_COUNT - 1);
    stat.r_zero       = (ro == '0);
    stat.out_free     = !out_valid || out_ready;
  end

  // Memory port selection.
  always_comb begin
    we    = 1'b0;
    wbit  = 1'b0;
    waddr = '0;
    raddr = '0;
    unique case (cmd.op)
      bpa_pkg::OP_CLR:    begin we = 1'b1; waddr = clr_addr; end
      bpa_pkg::OP_LAY:    begin we = 1'b1; wbit = 1'b1; waddr = idx(lk, lay_i); end
      bpa_pkg::OP_ATAKE:  begin we = 1'b1; waddr = idx(j, b); end
      bpa_pkg::OP_ASPLIT: begin we = (tgt < PAGES); wbit = 1'b1; waddr = idx(jm, tgt); end
      bpa_pkg::OP_MUP:    begin we = 1'b1; waddr = idx(mo, bud); end
      bpa_pkg::OP_MSET:   begin we = 1'b1; wbit = 1'b1; waddr = idx(mo, s); end
      bpa_pkg::OP_RTAKE:  begin we = 1'b1; waddr = idx(ro, rbase); end
      bpa_pkg::OP_ARD:    raddr = idx(j, b);
      bpa_pkg::OP_MRD:    raddr = idx(mo, bud);
      bpa_pkg::OP_RRD:    raddr = idx(ro, rbase);
      default:            ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wbit;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool      <= 9'd256;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) pool <= cfg_data;
      if (cmd.op == bpa_pkg::OP_RESULT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        bpa_pkg::OP_LOAD: begin
          op_q     <= in_req;
          page_q   <= in_page_w;
          k_q      <= OV'(kk);
          clr_addr <= '0;
          lay_i    <= '0;
          lay_n    <= (SW'(pool) > PAGES) ? PAGES : SW'(pool);
          j        <= OV'(kk);
          b        <= '0;
          s        <= in_page_w;
          mo       <= OV'(kk);
          ro       <= '0;
        end
        bpa_pkg::OP_CLR:    clr_addr <= clr_addr + IW'(1);
        bpa_pkg::OP_LAY:    lay_i <= lay_i + pw(lk);
        bpa_pkg::OP_ANEXT: begin
          if (b + pw(j) >= PAGES) begin
            j <= j + OV'(1);
            b <= '0;
          end else begin
            b <= b + pw(j);
          end
        end
        bpa_pkg::OP_ASPLIT: j <= jm;
        bpa_pkg::OP_MUP: begin
          s  <= s & ~pw(mo);
          mo <= mo + OV'(1);
        end
        bpa_pkg::OP_RNEXT:  ro <= ro + OV'(1);
        bpa_pkg::OP_RSPLIT: begin
          s  <= other;
          mo <= ro1;
          ro <= ro1;
        end
        bpa_pkg::OP_RESULT: begin
          out_status <= cmd.code;
          if (cmd.code != bpa_pkg::RES_OK || op_q == bpa_pkg::REQ_INIT) begin
            out_start <= 8'd0;
          end else if (op_q == bpa_pkg::REQ_ALLOC) begin
            out_start <= b[7:0];
          end else begin
            out_start <= page_q[7:0];
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// Buddy allocator controller
// Sequences clearing, layout, search, split and merge steps of a request.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bpa_pkg::dp_stat_t stat,
  output bpa_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ICLR, S_ILAY, S_AREAD, S_ACHK, S_ASPLIT,
    S_MTEST, S_MCHK, S_RREAD, S_RCHK, S_RSPLIT, S_DONE
  } state_t;

  state_t         state, state_next;
  bpa_pkg::res_t  res_code, res_code_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    res_code_next = res_code;
    cmd.op        = bpa_pkg::OP_NOP;
    cmd.code      = res_code;
    unique case (state)
      S_CLEAR: begin
        cmd.op = bpa_pkg::OP_CLR;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = bpa_pkg::OP_LOAD;
          res_code_next = bpa_pkg::RES_BAD;
          if (stat.req_in == bpa_pkg::REQ_INIT) state_next = S_ICLR;
          else if (stat.in_bad) state_next = S_DONE;
          else if (stat.req_in == bpa_pkg::REQ_ALLOC) state_next = S_AREAD;
          else if (stat.req_in == bpa_pkg::REQ_FREE) state_next = S_MTEST;
          else state_next = S_RREAD;
        end
      end
      S_ICLR: begin
        cmd.op = bpa_pkg::OP_CLR;
        if (stat.clr_last) state_next = S_ILAY;
      end
      S_ILAY: begin
        if (stat.lay_done) begin
          res_code_next = bpa_pkg::RES_OK;
          state_next    = S_DONE;
        end else begin
          cmd.op = bpa_pkg::OP_LAY;
        end
      end
      S_AREAD: begin
        cmd.op     = bpa_pkg::OP_ARD;
        state_next = S_ACHK;
      end
      S_ACHK: begin
        if (stat.rd_bit) begin
          cmd.op     = bpa_pkg::OP_ATAKE;
          state_next = S_ASPLIT;
        end else if (stat.a_last) begin
          res_code_next = bpa_pkg::RES_NOFREE;
          state_next    = S_DONE;
        end else begin
          cmd.op     = bpa_pkg::OP_ANEXT;
          state_next = S_AREAD;
        end
      end
      S_ASPLIT: begin
        if (stat.a_split_done) begin
          res_code_next = bpa_pkg::RES_OK;
          state_next    = S_DONE;
        end else begin
          cmd.op = bpa_pkg::OP_ASPLIT;
        end
      end
      S_MTEST, S_MCHK: begin
        if (state == S_MTEST && !stat.m_stop) begin
          cmd.op     = bpa_pkg::OP_MRD;
          state_next = S_MCHK;
        end else if (state == S_MCHK && stat.rd_bit) begin
          cmd.op     = bpa_pkg::OP_MUP;
          state_next = S_MTEST;
        end else begin
          // Merge ends here; a reserve may still have halves to give back.
          cmd.op = bpa_pkg::OP_MSET;
          if (stat.req_cur == bpa_pkg::REQ_RESERVE && !stat.r_zero) begin
            state_next = S_RSPLIT;
          end else begin
            res_code_next = bpa_pkg::RES_OK;
            state_next    = S_DONE;
          end
        end
      end
      S_RREAD: begin
        cmd.op     = bpa_pkg::OP_RRD;
        state_next = S_RCHK;
      end
      S_RCHK: begin
        if (stat.rd_bit) begin
          cmd.op = bpa_pkg::OP_RTAKE;
          if (stat.r_zero) begin
            res_code_next = bpa_pkg::RES_OK;
            state_next    = S_DONE;
          end else begin
            state_next = S_RSPLIT;
          end
        end else if (stat.r_last) begin
          res_code_next = bpa_pkg::RES_NOFREE;
          state_next    = S_DONE;
        end else begin
          cmd.op     = bpa_pkg::OP_RNEXT;
          state_next = S_RREAD;
        end
      end
      S_RSPLIT: begin
        cmd.op     = bpa_pkg::OP_RSPLIT;
        state_next = S_MTEST;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op     = bpa_pkg::OP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      res_code <= bpa_pkg::RES_OK;
    end else begin
      state    <= state_next;
      res_code <= res_code_next;
    end
  end

endmodule

### hw/rtl/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// Buddy page allocator
// Init, allocate, free and single-page reserve over a buddy free map.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake           Contents
//   s_*       in         s_tvalid/s_tready   request beat
//   m_*       out        m_tvalid/m_tready   result beat, one per request
//   cfg_*     in         cfg_valid/cfg_ready pool_pages register write
//
// Requests are served one at a time. Each free-map probe is a registered
// memory read followed by a check; each split or merge is a single write.
// An allocate probes block by block during its search; free and reserve
// walk the map order by order; init clears all ORDER_COUNT * 2**clog2(PAGE_COUNT)
// entries of the map and then lays out the pool one block at a time.
// After reset the same clearing sweep runs before the first request is taken;
// configuration writes are accepted at any time. A held result stalls only
// the finish of the next request, not its acceptance.
module buddy_page_allocator #(
  parameter int PAGE_COUNT  = 256,
  parameter int ORDER_COUNT = 9
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // req_type
  input  logic [23:0] s_tdata,   // page_index [7:0], request_count [16:8], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [1:0]  m_tuser,   // status
  output logic [7:0]  m_tdata,   // block_start
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data
);

  bpa_pkg::dp_cmd_t  cmd;
  bpa_pkg::dp_stat_t stat;
  bpa_pkg::res_t     out_status;

  // The pool size register can always take a write.
  assign cfg_ready = 1'b1;
  assign m_tuser   = out_status;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bpa_datapath #(
    .PAGE_COUNT  (PAGE_COUNT),
    .ORDER_COUNT (ORDER_COUNT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .in_req     (bpa_pkg::req_t'(s_tuser)),
    .in_page    (s_tdata[7:0]),
    .in_count   (s_tdata[16:8]),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_start  (m_tdata)
  );

endmodule

### tb/sv/tb_buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// Buddy page allocator testbench
// Drives init, allocate, free and reserve requests through the request stream,
// predicts every result beat from an internal copy of the free map, and
// compares each result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_buddy_page_allocator;

  localparam int PAGES  = 256;
  localparam int ORDERS = 9;

  typedef struct packed {
    bpa_pkg::res_t status;
    logic [7:0]    start;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [1:0]  s_tuser = '0;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [1:0]  m_tuser;
  logic [7:0]  m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = '0;

  // Predicted free map, one mark per order and block start.
  bit            map_free [ORDERS][PAGES];
  int unsigned   pool_size;
  alloc_result_t pending_results [$];
  int            error_count;
  int            result_count;
  int            request_count;
  bit            idle_enabled;

  // The clearing sweep after reset and each init both step through every map entry,
  // so even the most init-heavy run stays far below this bound.
  localparam int RUN_LIMIT = 20_000_000;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  buddy_page_allocator #(
    .PAGE_COUNT (PAGES),
    .ORDER_COUNT(ORDERS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),   // req_type
    .s_tdata  (s_tdata),   // page_index [7:0], request_count [16:8], zero fill
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),   // status
    .m_tdata  (m_tdata),   // block_start
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // Marks a block free and merges it with free buddies, stopping at the top order.
  function automatic void merge_free(int unsigned blk, int unsigned ord);
    int unsigned bud;
    while (ord + 1 < ORDERS) begin
      bud = blk ^ (1 << ord);
      if (bud >= PAGES || !map_free[ord][bud]) break;
      map_free[ord][bud] = 0;
      blk &= ~(1 << ord);
      ord++;
    end
    map_free[ord][blk] = 1;
  endfunction

  // Order of a page count, or ORDERS when the count cannot be served.
  function automatic int unsigned order_of_count(int unsigned cnt);
    int unsigned k;
    k = 0;
    if (cnt == 0) return ORDERS;
    while (k < 31 && (1 << k) < cnt) k++;
    if (k >= ORDERS || (1 << k) > PAGES) return ORDERS;
    return k;
  endfunction

  // Applies one request to the predicted map and returns its result.
  function automatic alloc_result_t apply_request(bpa_pkg::req_t req, int unsigned page,
                                                  int unsigned cnt);
    alloc_result_t r;
    int unsigned n, i, k, j, b, o, half, base, other;
    bit found;
    r.status = bpa_pkg::RES_OK;
    r.start  = '0;
    found = 0;
    case (req)
      bpa_pkg::REQ_INIT: begin
        n = (pool_size > PAGES) ? PAGES : pool_size;
        foreach (map_free[x, y]) map_free[x][y] = 0;
        i = 0;
        while (i < n) begin
          k = 0;
          while (k + 1 < ORDERS && (2 << k) <= n - i) k++;
          map_free[k][i] = 1;
          i += 1 << k;
        end
      end
      bpa_pkg::REQ_ALLOC: begin
        k = order_of_count(cnt);
        if (k >= ORDERS) begin
          r.status = bpa_pkg::RES_BAD;
        end else begin
          // Smallest sufficient order first, lowest address within it.
          for (j = k; j < ORDERS && !found; j++) begin
            for (b = 0; b < PAGES; b += 1 << j) begin
              if (map_free[j][b]) begin
                found = 1;
                break;
              end
            end
            if (found) break;
          end
          if (!found) begin
            r.status = bpa_pkg::RES_NOFREE;
          end else begin
            map_free[j][b] = 0;
            while (j > k) begin
              j--;
              if (b + (1 << j) < PAGES) map_free[j][b + (1 << j)] = 1;
            end
            r.start = 8'(b);
          end
        end
      end
      bpa_pkg::REQ_FREE: begin
        k = order_of_count(cnt);
        if (k >= ORDERS || (page & ((1 << k) - 1)) != 0 || page + (1 << k) > PAGES) begin
          r.status = bpa_pkg::RES_BAD;
        end else begin
          merge_free(page, k);
          r.start = 8'(page);
        end
      end
      default: begin
        if (page >= PAGES) begin
          r.status = bpa_pkg::RES_BAD;
        end else begin
          for (o = 0; o < ORDERS; o++) begin
            base = page & ~((1 << o) - 1);
            if (map_free[o][base]) begin
              map_free[o][base] = 0;
              found = 1;
              break;
            end
          end
          if (!found) begin
            r.status = bpa_pkg::RES_NOFREE;
          end else begin
            // Give back every half of the containing block except the page itself.
            while (o > 0) begin
              half  = 1 << (o - 1);
              base  = page & ~((1 << o) - 1);
              other = (page & half) ? base : base + half;
              merge_free(other, o - 1);
              o--;
            end
            r.start = 8'(page);
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch on result %0d: %s got %0d, expected %0d",
             result_count, what, got, want);
    error_count++;
  endtask

  task automatic idle_gap();
    if (idle_enabled && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 13)) @(negedge clk);
  endtask

  // Sends one request beat and queues its predicted result on acceptance.
  // Valid is raised on a falling edge after the previous beat dropped it and any idle gap.
  task automatic send_request(bpa_pkg::req_t req, int unsigned page, int unsigned cnt);
    idle_gap();
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {7'd0, cnt[8:0], page[7:0]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(apply_request(req, page, cnt));
    request_count++;
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // Writes pool_pages once the block is idle, after every pending result has been received.
  task automatic write_pool_size(int unsigned value);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value[8:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pool_size = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result receiver with random stall bursts.
  initial begin
    alloc_result_t want;
    forever begin
      @(negedge clk);
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $display("result beat with no request waiting: status %0d start %0d",
                   m_tuser, m_tdata);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (m_tuser !== want.status) report_mismatch("status", m_tuser, want.status);
          if (m_tdata !== want.start) report_mismatch("block_start", m_tdata, want.start);
        end
        result_count++;
      end
    end
  end

  function automatic int unsigned random_count();
    int unsigned k;
    k = $urandom_range(0, 8);
    case ($urandom_range(0, 3))
      0: return 1 << k;
      1: return $urandom_range(1, 1 << k);
      2: return $urandom_range(0, 511);
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  task automatic test_init_layouts();
    // Pool sizes at the extremes, an odd size, and out-of-range values.
    write_pool_size(256);
    send_request(bpa_pkg::REQ_INIT, 0, 1);
    write_pool_size(1);
    send_request(bpa_pkg::REQ_INIT, 0, 1);
    send_request(bpa_pkg::REQ_ALLOC, 0, 2);
    send_request(bpa_pkg::REQ_ALLOC, 0, 1);
    send_request(bpa_pkg::REQ_ALLOC, 0, 1);
    write_pool_size(0);
    send_request(bpa_pkg::REQ_INIT, 0, 1);
    send_request(bpa_pkg::REQ_RESERVE, 0, 1);
    write_pool_size(511);
    send_request(bpa_pkg::REQ_INIT, 255, 511);
    write_pool_size(173);
    send_request(bpa_pkg::REQ_INIT, 0, 1);
  endtask

  task automatic test_directed_requests();
    send_request(bpa_pkg::REQ_ALLOC, 0, 0);      // zero count
    send_request(bpa_pkg::REQ_ALLOC, 0, 257);    // rounds past the pool
    send_request(bpa_pkg::REQ_ALLOC, 0, 3);
    send_request(bpa_pkg::REQ_ALLOC, 0, 128);
    send_request(bpa_pkg::REQ_FREE, 0, 128);
    send_request(bpa_pkg::REQ_FREE, 4, 8);       // misaligned
    send_request(bpa_pkg::REQ_FREE, 255, 2);     // runs past the pool end
    send_request(bpa_pkg::REQ_FREE, 0, 256);     // double free of a top-order block
    send_request(bpa_pkg::REQ_RESERVE, 255, 1);
    send_request(bpa_pkg::REQ_RESERVE, 255, 1);  // page no longer free
    send_request(bpa_pkg::REQ_RESERVE, 170, 1);
    send_request(bpa_pkg::REQ_FREE, 255, 1);
  endtask

  // Mostly alloc/free/reserve mixes over a held pool, with occasional re-inits.
  task automatic test_random_traffic(int unsigned items);
    int unsigned starts [$];
    int unsigned sizes [$];
    int unsigned pick, sel;
    alloc_result_t r;
    repeat (items) begin
      sel = $urandom_range(0, 99);
      if (sel < 2) begin
        send_request(bpa_pkg::REQ_INIT, $urandom_range(0, 255), random_count());
        starts.delete();
        sizes.delete();
      end else if (sel < 45) begin
        pick = random_count();
        send_request(bpa_pkg::REQ_ALLOC, $urandom_range(0, 255), pick);
        r = pending_results[$];
        if (r.status == bpa_pkg::RES_OK) begin
          starts.push_back(r.start);
          sizes.push_back(pick);
        end
      end else if (sel < 80 && starts.size() != 0) begin
        pick = $urandom_range(0, starts.size() - 1);
        send_request(bpa_pkg::REQ_FREE, starts[pick], sizes[pick]);
        starts.delete(pick);
        sizes.delete(pick);
      end else if (sel < 90) begin
        send_request(bpa_pkg::REQ_RESERVE, $urandom_range(0, 255), random_count());
      end else begin
        send_request(bpa_pkg::REQ_FREE, $urandom_range(0, 255), random_count());
      end
    end
  endtask

  initial begin
    error_count   = 0;
    result_count  = 0;
    request_count = 0;
    pool_size     = 256;
    idle_enabled  = 1;
    foreach (map_free[x, y]) map_free[x][y] = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_init_layouts();
    test_directed_requests();
    test_random_traffic(800);
    write_pool_size($urandom_range(1, 255));
    send_request(bpa_pkg::REQ_INIT, 0, 1);
    test_random_traffic(600);
    write_pool_size(256);
    send_request(bpa_pkg::REQ_INIT, 0, 1);
    idle_enabled = 0;
    test_random_traffic(400);

    while (pending_results.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("Sent %0d requests (init, allocate, free, reserve) and checked %0d results",
             request_count, result_count);
    $display("over several pool sizes, with random idling on both streams.");
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### buddy_page_allocator.f
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_datapath.sv
hw/rtl/bpa_ctrl.sv
hw/rtl/buddy_page_allocator.sv
tb/sv/tb_buddy_page_allocator.sv
